// ===== sv/tec_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tec_pkg
// Shared codes, widths and constants of the triple encoder counter core.
// ----------------------------------------------------------------------------
package tec_pkg;

    // input word fields
    localparam int CMD_W      = 2;
    localparam int ENC_SEL_W  = 2;
    localparam int LEVELS_W   = 6;
    localparam int COUNT_W    = 16;
    localparam int BYTE_W     = 8;

    typedef logic [CMD_W-1:0]     cmd_t;
    typedef logic [ENC_SEL_W-1:0] enc_sel_t;
    typedef logic [LEVELS_W-1:0]  levels_t;
    typedef logic [COUNT_W-1:0]   count_t;
    typedef logic [BYTE_W-1:0]    byte_t;

    // command codes
    localparam cmd_t CMD_EDGE   = 2'd0;
    localparam cmd_t CMD_TICK   = 2'd1;
    localparam cmd_t CMD_POLL   = 2'd2;
    localparam cmd_t CMD_PRESET = 2'd3;

    // frame and gripper bytes
    localparam byte_t FRAME_START = 8'hF5;
    localparam byte_t GRIP_GRAB   = 8'h1F;
    localparam byte_t GRIP_OPEN   = 8'h11;

    // reset value of the preset register and of every count
    localparam count_t PRESET_RESET = 16'd300;

    // default sizes
    localparam int ENCODERS_DEFAULT    = 3;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

endpackage
`default_nettype wire

// ===== sv/tec_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tec_front
// Accepts input words, keeps the encoder counts, pending marks, gripper byte
// and heartbeat, and pushes a frame snapshot into the queue on each tick.
// ----------------------------------------------------------------------------
module tec_front #(
    parameter int ENCODERS = tec_pkg::ENCODERS_DEFAULT,
    parameter int SNAP_W   = 16 * ENCODERS + 9
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    count_preset_wr_en,
    input  wire tec_pkg::count_t   count_preset,
    input  wire                    in_valid,
    output logic                   in_stall,
    input  wire tec_pkg::cmd_t     cmd,
    input  wire tec_pkg::enc_sel_t edge_encoder,
    input  wire                    edge_on_b,
    input  wire tec_pkg::levels_t  phase_levels,
    input  wire                    grip_pressed,
    output logic                   push,
    output logic [SNAP_W-1:0]      push_data,
    input  wire                    queue_full
);
    import tec_pkg::*;

    localparam int LV_W = 2 * ENCODERS + LEVELS_W;

    count_t                 preset_reg;
    count_t                 count_reg [ENCODERS];
    count_t                 count_next[ENCODERS];
    logic [ENCODERS-1:0]    a_pend_reg, a_pend_next;
    logic [ENCODERS-1:0]    b_pend_reg, b_pend_next;
    byte_t                  grip_reg, grip_next;
    logic                   beat_reg, beat_next;
    logic                   accept;
    logic [LV_W-1:0]        levels_ext;

    // a tick waits only while the frame queue is full
    assign in_stall = (cmd == CMD_TICK) && queue_full;
    assign accept   = in_valid && !in_stall;
    assign push     = accept && (cmd == CMD_TICK);

    // levels above the input width read as zero
    assign levels_ext = {{(2 * ENCODERS){1'b0}}, phase_levels};

    // snapshot: counts in the low bits, gripper byte, heartbeat after the tick
    always_comb
    begin
        for (int k = 0; k < ENCODERS; k++)
        begin
            push_data[16 * k +: 16] = count_reg[k];
        end
        push_data[16 * ENCODERS +: 8] = grip_reg;
        push_data[SNAP_W-1]           = !beat_reg;
    end

    // next state per command
    always_comb
    begin
        a_pend_next = a_pend_reg;
        b_pend_next = b_pend_reg;
        grip_next   = grip_reg;
        beat_next   = beat_reg;
        for (int k = 0; k < ENCODERS; k++)
        begin
            count_next[k] = count_reg[k];
        end
        if (accept)
        begin
            case (cmd)
                CMD_EDGE:
                begin
                    for (int k = 0; k < ENCODERS; k++)
                    begin
                        if (int'(edge_encoder) == k)
                        begin
                            if (!edge_on_b)
                            begin
                                if (b_pend_reg[k])
                                begin
                                    count_next[k]  = count_reg[k] + 16'd1;
                                    a_pend_next[k] = 1'b0;
                                    b_pend_next[k] = 1'b0;
                                end
                                else
                                begin
                                    a_pend_next[k] = 1'b1;
                                end
                            end
                            else
                            begin
                                if (a_pend_reg[k])
                                begin
                                    count_next[k]  = count_reg[k] - 16'd1;
                                    a_pend_next[k] = 1'b0;
                                    b_pend_next[k] = 1'b0;
                                end
                                else
                                begin
                                    b_pend_next[k] = 1'b1;
                                end
                            end
                        end
                    end
                end
                CMD_TICK:
                begin
                    beat_next = !beat_reg;
                end
                CMD_POLL:
                begin
                    grip_next = grip_pressed ? GRIP_GRAB : GRIP_OPEN;
                    for (int k = 0; k < ENCODERS; k++)
                    begin
                        if (levels_ext[2 * k] && levels_ext[2 * k + 1])
                        begin
                            a_pend_next[k] = 1'b0;
                            b_pend_next[k] = 1'b0;
                        end
                    end
                end
                CMD_PRESET:
                begin
                    for (int k = 0; k < ENCODERS; k++)
                    begin
                        count_next[k] = preset_reg;
                    end
                end
                default:
                begin
                    beat_next = beat_reg;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preset_reg <= PRESET_RESET;
            a_pend_reg <= '0;
            b_pend_reg <= '0;
            grip_reg   <= '0;
            beat_reg   <= 1'b0;
            for (int k = 0; k < ENCODERS; k++)
            begin
                count_reg[k] <= PRESET_RESET;
            end
        end
        else
        begin
            if (count_preset_wr_en)
            begin
                preset_reg <= count_preset;
            end
            a_pend_reg <= a_pend_next;
            b_pend_reg <= b_pend_next;
            grip_reg   <= grip_next;
            beat_reg   <= beat_next;
            for (int k = 0; k < ENCODERS; k++)
            begin
                count_reg[k] <= count_next[k];
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/tec_frame_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tec_frame_queue
// Short first-in first-out queue of frame snapshots between front and back.
// ----------------------------------------------------------------------------
module tec_frame_queue #(
    parameter int WIDTH = 57,
    parameter int DEPTH = tec_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               push,
    input  wire [WIDTH-1:0]   push_data,
    output logic              full,
    input  wire               pop,
    output logic              not_empty,
    output logic [WIDTH-1:0]  head_data
);
    import tec_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0]  entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              do_push, do_pop;

    assign full      = (fill_reg == FULL_CNT);
    assign not_empty = (fill_reg != '0);
    assign head_data = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // pointer and fill count updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // snapshot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ===== sv/tec_serializer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tec_serializer
// Turns the queue's head snapshot into one frame, a byte per cycle while
// out_stall is low, with a running checksum and a registered output word.
// ----------------------------------------------------------------------------
module tec_serializer #(
    parameter int ENCODERS = tec_pkg::ENCODERS_DEFAULT,
    parameter int SNAP_W   = 16 * ENCODERS + 9
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   head_valid,
    input  wire [SNAP_W-1:0]      head_data,
    output logic                  pop,
    output logic                  out_valid,
    input  wire                   out_stall,
    output tec_pkg::byte_t        out_byte,
    output logic                  last_byte,
    output logic                  led_level
);
    import tec_pkg::*;

    localparam int FRAME_LEN = 2 * ENCODERS + 3;
    localparam int IDX_W     = $clog2(FRAME_LEN);
    localparam logic [IDX_W-1:0] GRIP_IDX = IDX_W'(2 * ENCODERS + 1);
    localparam logic [IDX_W-1:0] SUM_IDX  = IDX_W'(2 * ENCODERS + 2);

    logic [IDX_W-1:0]  idx_reg, idx_next;
    byte_t             sum_reg, sum_next;
    logic              valid_reg, valid_next;
    byte_t             byte_reg, byte_next;
    logic              last_reg, last_next;
    logic              led_reg, led_next;
    logic              slot_free, emit;
    logic [IDX_W-1:0]  pos, enc_pos;
    count_t            sel_count;
    byte_t             sel_byte;

    // output slot takes a new word when empty or being taken
    assign slot_free = !valid_reg || !out_stall;
    assign emit      = slot_free && head_valid;
    assign pop       = emit && (idx_reg == SUM_IDX);

    // pick the count byte for this position
    assign pos     = idx_reg - 1'b1;
    assign enc_pos = pos >> 1;

    always_comb
    begin
        sel_count = '0;
        for (int k = 0; k < ENCODERS; k++)
        begin
            if (enc_pos == IDX_W'(k))
            begin
                sel_count = head_data[16 * k +: 16];
            end
        end
    end

    // byte at the current frame position
    always_comb
    begin
        if (idx_reg == '0)
        begin
            sel_byte = FRAME_START;
        end
        else if (idx_reg == GRIP_IDX)
        begin
            sel_byte = head_data[16 * ENCODERS +: 8];
        end
        else if (idx_reg == SUM_IDX)
        begin
            sel_byte = sum_reg;
        end
        else
        begin
            sel_byte = pos[0] ? sel_count[7:0] : sel_count[15:8];
        end
    end

    // frame position, checksum and output word
    always_comb
    begin
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        led_next   = led_reg;
        if (slot_free)
        begin
            valid_next = head_valid;
        end
        if (emit)
        begin
            byte_next = sel_byte;
            last_next = (idx_reg == SUM_IDX);
            led_next  = head_data[SNAP_W-1];
            if (idx_reg == SUM_IDX)
            begin
                idx_next = '0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
            if (idx_reg == '0)
            begin
                sum_next = '0;
            end
            else if (idx_reg != SUM_IDX)
            begin
                sum_next = sum_reg + sel_byte;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
        led_reg  <= led_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign last_byte = last_reg;
    assign led_level = led_reg;

endmodule
`default_nettype wire

// ===== sv/triple_encoder_counter_telemetry_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// triple_encoder_counter_telemetry_core
// Quadrature encoder counters with a byte-serial telemetry frame output.
// ----------------------------------------------------------------------------
// The core takes one input word per clock: phase edges, level polls and
// preset loads are absorbed in the cycle they are accepted and give no
// output. A timer tick toggles the heartbeat and captures the counts,
// gripper byte and heartbeat into a frame queue of QUEUE_DEPTH entries; the
// serializer then sends 2*ENCODERS+3 bytes (nine for three encoders), one per
// cycle while out_stall is low: 0xF5, each count high byte first, the
// gripper byte and the 8-bit sum of the bytes between start and sum. A tick
// is stalled only while the frame queue is full, so the frame serializer's
// one-byte-per-cycle output sets the sustained tick rate; all other words
// flow at one per cycle. The user writes count_preset with count_preset_wr_en
// only while the core is idle; the core itself does not enforce this.
// ----------------------------------------------------------------------------
module triple_encoder_counter_telemetry_core #(
    parameter int ENCODERS    = tec_pkg::ENCODERS_DEFAULT,
    parameter int QUEUE_DEPTH = tec_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    count_preset_wr_en,
    input  wire tec_pkg::count_t   count_preset,
    input  wire                    in_valid,
    output logic                   in_stall,
    input  wire tec_pkg::cmd_t     cmd,
    input  wire tec_pkg::enc_sel_t edge_encoder,
    input  wire                    edge_on_b,
    input  wire tec_pkg::levels_t  phase_levels,
    input  wire                    grip_pressed,
    output logic                   out_valid,
    input  wire                    out_stall,
    output tec_pkg::byte_t         out_byte,
    output logic                   last_byte,
    output logic                   led_level
);
    import tec_pkg::*;

    localparam int SNAP_W = COUNT_W * ENCODERS + BYTE_W + 1;

    logic               push, pop;
    logic               queue_full, queue_not_empty;
    logic [SNAP_W-1:0]  push_data, head_data;

    // front: state update and frame capture
    tec_front #(
        .ENCODERS (ENCODERS),
        .SNAP_W   (SNAP_W)
    ) u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .count_preset_wr_en (count_preset_wr_en),
        .count_preset       (count_preset),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .cmd                (cmd),
        .edge_encoder       (edge_encoder),
        .edge_on_b          (edge_on_b),
        .phase_levels       (phase_levels),
        .grip_pressed       (grip_pressed),
        .push               (push),
        .push_data          (push_data),
        .queue_full         (queue_full)
    );

    // frame queue between front and back
    tec_frame_queue #(
        .WIDTH (SNAP_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .head_data (head_data)
    );

    // back: frame serializer
    tec_serializer #(
        .ENCODERS (ENCODERS),
        .SNAP_W   (SNAP_W)
    ) u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (queue_not_empty),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .last_byte  (last_byte),
        .led_level  (led_level)
    );

endmodule
`default_nettype wire
